@@ sv/whr_pkg.sv @@
// ----------------------------------------------------------------------------
// whr_pkg
// Shared constants, widths and types of the wavetable Hermite reader.
// ----------------------------------------------------------------------------
package whr_pkg;

   // Table geometry (power of two, 4 to 2048, bounded by the index field)
   localparam int TABLE_SIZE  = 2048;
   localparam int INDEX_BITS  = 11;
   localparam int ADDR_BITS   = $clog2(TABLE_SIZE);
   localparam int NUM_BANKS   = 4;
   localparam int BANK_BITS   = $clog2(NUM_BANKS);
   localparam int ROW_BITS    = ADDR_BITS - BANK_BITS;
   localparam int BANK_DEPTH  = TABLE_SIZE / NUM_BANKS;

   // Sample and phase formats
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 16;

   // Widths of the doubled Hermite terms
   localparam int DIFF_BITS   = SAMPLE_BITS + 1;
   localparam int VV_BITS     = SAMPLE_BITS + 2;
   localparam int A_BITS      = SAMPLE_BITS + 4;
   localparam int B_BITS      = SAMPLE_BITS + 5;
   localparam int P_BITS      = SAMPLE_BITS + 6;
   localparam int PROD_BITS   = P_BITS + FRAC_BITS + 1;
   localparam int SUM_BITS    = PROD_BITS + 1;
   localparam int Y_BITS      = P_BITS + 1;

   // Rounding offsets and saturation limits
   localparam logic signed [SUM_BITS-1:0] RND_HALF_F  = SUM_BITS'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [SUM_BITS-1:0] RND_HALF_F1 = SUM_BITS'(1) <<< FRAC_BITS;
   localparam logic signed [Y_BITS-1:0]   SAT_HI      =
      Y_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [Y_BITS-1:0]   SAT_LO      = ~SAT_HI;

   // Function codes of an input word
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   // Difference terms handed from the fetch stages to the arithmetic pipeline
   typedef struct packed {
      logic                          vld;
      logic signed [SAMPLE_BITS-1:0] v1;
      logic signed [DIFF_BITS-1:0]   s0;
      logic signed [DIFF_BITS-1:0]   s1;
      logic signed [VV_BITS-1:0]     vv;
      logic [FRAC_BITS-1:0]          frac;
   } diff_type;

endpackage

@@ sv/whr_ifs.sv @@
// ----------------------------------------------------------------------------
// whr_ifs
// Request and response channels of the wavetable Hermite reader.
// ----------------------------------------------------------------------------
interface whr_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   func;
   logic [whr_pkg::INDEX_BITS-1:0]         index;
   logic [15:0]                            phase_frac;
   logic signed [whr_pkg::SAMPLE_BITS-1:0] entry_value;

   modport source (output valid, func, index, phase_frac, entry_value, input ready);
   modport sink   (input valid, func, index, phase_frac, entry_value, output ready);
endinterface

interface whr_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [whr_pkg::SAMPLE_BITS-1:0] sample_out;
   logic                                   clipped;

   modport source (output valid, sample_out, clipped, input ready);
   modport sink   (input valid, sample_out, clipped, output ready);
endinterface

@@ sv/wavetable_hermite_reader.sv @@
// ----------------------------------------------------------------------------
// wavetable_hermite_reader
// Wave table with 4-point cubic Hermite read-out, saturated to Q1.15.
// ----------------------------------------------------------------------------
//  channel   dir   fields                                      word
//  req_bus   in    func, index, phase_frac, entry_value        write or read
//  rsp_bus   out   sample_out, clipped                         one per read
//
//  One word per cycle in steady state unless rsp_bus stalls; a read answers
//  through the nine register stages, a write is stored and answers nothing.
//  The table is split into four banks on the low index bits, so the four
//  neighbor samples come out of four bank read ports in the same cycle.
//  Reset clears only the valid bits; table contents are undefined until
//  written, and no clearing pass runs.
//  Each stage holds under back-pressure and loads as soon as it is empty,
//  so bubbles close up; a waiting response blocks new requests only once
//  all nine stages hold read words.
// ----------------------------------------------------------------------------
module wavetable_hermite_reader (
   input logic       clock,
   input logic       reset,
   whr_req_if.sink   req_bus,
   whr_rsp_if.source rsp_bus
);

   whr_pkg::diff_type diff;
   logic              diff_ready;

   // Fetch taps and differences
   whr_fetch u_fetch (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .diff_out   (diff),
      .diff_ready (diff_ready)
   );

   // Evaluate the polynomial
   whr_interp u_interp (
      .clock      (clock),
      .reset      (reset),
      .diff_in    (diff),
      .diff_ready (diff_ready),
      .rsp_bus    (rsp_bus)
   );

endmodule

@@ sv/whr_bank.sv @@
// ----------------------------------------------------------------------------
// whr_bank
// One bank of the wave table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module whr_bank (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [whr_pkg::ROW_BITS-1:0]           wr_row,
   input  logic signed [whr_pkg::SAMPLE_BITS-1:0] wr_data,
   input  logic                                   rd_en,
   input  logic [whr_pkg::ROW_BITS-1:0]           rd_row,
   output logic signed [whr_pkg::SAMPLE_BITS-1:0] rd_data
);

   logic signed [whr_pkg::SAMPLE_BITS-1:0] mem [whr_pkg::BANK_DEPTH];
   logic signed [whr_pkg::SAMPLE_BITS-1:0] rd_data_ff;

   // Store on write, fetch on read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_row] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_row];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/whr_fetch.sv @@
// ----------------------------------------------------------------------------
// whr_fetch
// Accepts request words, writes the banked table, reads the four neighbor
// samples of a phase and forms the first Hermite difference terms.
// ----------------------------------------------------------------------------
module whr_fetch (
   input  logic              clock,
   input  logic              reset,
   whr_req_if.sink           req_bus,
   output whr_pkg::diff_type diff_out,
   input  logic              diff_ready
);

   localparam int AB = whr_pkg::ADDR_BITS;
   localparam int BB = whr_pkg::BANK_BITS;
   localparam int NB = whr_pkg::NUM_BANKS;

   logic          ld1, ld2;
   logic          accept, rd_accept, wr_accept;
   logic [AB-1:0] idx, base;

   logic [whr_pkg::ROW_BITS-1:0]           rd_row [NB];
   logic [NB-1:0]                          wr_sel;
   logic signed [whr_pkg::SAMPLE_BITS-1:0] bank_q [NB];
   logic signed [whr_pkg::SAMPLE_BITS-1:0] vtap   [NB];

   logic                          vld1_ff, vld1_in;
   logic [BB-1:0]                 base_lo_ff;
   logic [whr_pkg::FRAC_BITS-1:0] frac1_ff;

   logic                                   vld2_ff, vld2_in;
   logic signed [whr_pkg::SAMPLE_BITS-1:0] v1_ff, v1_in;
   logic signed [whr_pkg::DIFF_BITS-1:0]   s0_ff, s0_in, s1_ff, s1_in;
   logic signed [whr_pkg::VV_BITS-1:0]     vv_ff, vv_in;
   logic [whr_pkg::FRAC_BITS-1:0]          frac2_ff;

   // Stall chain: a stage loads when empty or when its successor loads
   assign ld2 = !vld2_ff || diff_ready;
   assign ld1 = !vld1_ff || ld2;

   assign req_bus.ready = ld1;
   assign accept        = req_bus.valid && ld1;
   assign rd_accept     = accept && (req_bus.func == whr_pkg::FUNC_READ);
   assign wr_accept     = accept && (req_bus.func == whr_pkg::FUNC_WRITE);

   // Wrap the index; the window starts one entry below it
   assign idx  = req_bus.index[AB-1:0];
   assign base = idx - AB'(1);

   // Four consecutive entries fall in four distinct banks
   for (genvar b = 0; b < NB; b++) begin : g_bank
      logic [BB-1:0] offs;
      logic [AB-1:0] entry;

      assign offs      = BB'(b) - base[BB-1:0];
      assign entry     = base + AB'(offs);
      assign rd_row[b] = entry[AB-1:BB];
      assign wr_sel[b] = wr_accept && (idx[BB-1:0] == BB'(b));

      whr_bank u_bank (
         .clock   (clock),
         .wr_en   (wr_sel[b]),
         .wr_row  (idx[AB-1:BB]),
         .wr_data (req_bus.entry_value),
         .rd_en   (rd_accept),
         .rd_row  (rd_row[b]),
         .rd_data (bank_q[b])
      );
   end

   // Stage 1: table read in flight, hold bank order and fraction
   assign vld1_in = rd_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else if (ld1) begin
         vld1_ff <= vld1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_accept) begin
         base_lo_ff <= base[BB-1:0];
         frac1_ff   <= req_bus.phase_frac[whr_pkg::FRAC_BITS-1:0];
      end
   end

   // Stage 2: put the taps back in phase order and take differences
   always_comb begin
      for (int k = 0; k < NB; k++) begin
         vtap[k] = bank_q[base_lo_ff + BB'(k)];
      end
      vld2_in = vld1_ff;
      v1_in   = vtap[1];
      s0_in   = whr_pkg::DIFF_BITS'(vtap[2]) - whr_pkg::DIFF_BITS'(vtap[0]);
      s1_in   = whr_pkg::DIFF_BITS'(vtap[3]) - whr_pkg::DIFF_BITS'(vtap[1]);
      vv_in   = (whr_pkg::VV_BITS'(vtap[1]) - whr_pkg::VV_BITS'(vtap[2])) <<< 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld2_ff <= 1'b0;
      end else if (ld2) begin
         vld2_ff <= vld2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld2 && vld1_ff) begin
         v1_ff    <= v1_in;
         s0_ff    <= s0_in;
         s1_ff    <= s1_in;
         vv_ff    <= vv_in;
         frac2_ff <= frac1_ff;
      end
   end

   assign diff_out.vld  = vld2_ff;
   assign diff_out.v1   = v1_ff;
   assign diff_out.s0   = s0_ff;
   assign diff_out.s1   = s1_ff;
   assign diff_out.vv   = vv_ff;
   assign diff_out.frac = frac2_ff;

endmodule

@@ sv/whr_interp.sv @@
// ----------------------------------------------------------------------------
// whr_interp
// Horner evaluation of the Hermite polynomial in seven stages: coefficients A
// and B, a multiply alternating with a round-and-add, then saturation into the response register.
// ----------------------------------------------------------------------------
module whr_interp (
   input  logic              clock,
   input  logic              reset,
   input  whr_pkg::diff_type diff_in,
   output logic              diff_ready,
   whr_rsp_if.source         rsp_bus
);

   localparam int SB = whr_pkg::SAMPLE_BITS;
   localparam int FB = whr_pkg::FRAC_BITS;
   localparam int PB = whr_pkg::PROD_BITS;
   localparam int MB = whr_pkg::SUM_BITS;

   logic ld3, ld4, ld5, ld6, ld7, ld8, ld9;
   logic vld3_ff, vld4_ff, vld5_ff, vld6_ff, vld7_ff, vld8_ff, vld9_ff;

   logic signed [SB-1:0]               v1_3_ff, v1_4_ff, v1_5_ff, v1_6_ff, v1_7_ff, v1_8_ff;
   logic signed [whr_pkg::DIFF_BITS-1:0] s0_3_ff, s0_4_ff, s0_5_ff, s0_6_ff;
   logic [FB-1:0]                      f3_ff, f4_ff, f5_ff, f6_ff, f7_ff;

   logic signed [whr_pkg::A_BITS-1:0]  w3, a3_in, a3_ff;
   logic signed [whr_pkg::B_BITS-1:0]  b3_in, b3_ff, b4_ff;
   logic signed [PB-1:0]               prod4_in, prod4_ff, prod6_in, prod6_ff;
   logic signed [PB-1:0]               prod8_in, prod8_ff;
   logic signed [MB-1:0]               sum5, sum7, sum9;
   logic signed [whr_pkg::P_BITS-1:0]  p5_in, p5_ff, p7_in, p7_ff, t9;
   logic signed [whr_pkg::Y_BITS-1:0]  y9;
   logic signed [SB-1:0]               out9_in, out9_ff;
   logic                               clip9_in, clip9_ff;

   // Stall chain from the response register back to the input
   assign ld9 = !vld9_ff || rsp_bus.ready;
   assign ld8 = !vld8_ff || ld9;
   assign ld7 = !vld7_ff || ld8;
   assign ld6 = !vld6_ff || ld7;
   assign ld5 = !vld5_ff || ld6;
   assign ld4 = !vld4_ff || ld5;
   assign ld3 = !vld3_ff || ld4;
   assign diff_ready = ld3;

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
         vld6_ff <= 1'b0;
         vld7_ff <= 1'b0;
         vld8_ff <= 1'b0;
         vld9_ff <= 1'b0;
      end else begin
         if (ld3) vld3_ff <= diff_in.vld;
         if (ld4) vld4_ff <= vld3_ff;
         if (ld5) vld5_ff <= vld4_ff;
         if (ld6) vld6_ff <= vld5_ff;
         if (ld7) vld7_ff <= vld6_ff;
         if (ld8) vld8_ff <= vld7_ff;
         if (ld9) vld9_ff <= vld8_ff;
      end
   end

   // Stage 3: leading coefficients A and B
   always_comb begin
      w3    = whr_pkg::A_BITS'(diff_in.s0) + whr_pkg::A_BITS'(diff_in.vv);
      a3_in = w3 + whr_pkg::A_BITS'(diff_in.vv) + whr_pkg::A_BITS'(diff_in.s1);
      b3_in = whr_pkg::B_BITS'(w3) + whr_pkg::B_BITS'(a3_in);
   end

   always_ff @(posedge clock) begin
      if (ld3 && diff_in.vld) begin
         a3_ff   <= a3_in;
         b3_ff   <= b3_in;
         s0_3_ff <= diff_in.s0;
         v1_3_ff <= diff_in.v1;
         f3_ff   <= diff_in.frac;
      end
   end

   // Stage 4: A times fraction
   assign prod4_in = PB'(a3_ff) * PB'($signed({1'b0, f3_ff}));

   always_ff @(posedge clock) begin
      if (ld4 && vld3_ff) begin
         prod4_ff <= prod4_in;
         b4_ff    <= b3_ff;
         s0_4_ff  <= s0_3_ff;
         v1_4_ff  <= v1_3_ff;
         f4_ff    <= f3_ff;
      end
   end

   // Stage 5: subtract B, round half up to p1
   always_comb begin
      sum5  = MB'(prod4_ff) - (MB'(b4_ff) <<< FB) + whr_pkg::RND_HALF_F;
      p5_in = whr_pkg::P_BITS'(sum5 >>> FB);
   end

   always_ff @(posedge clock) begin
      if (ld5 && vld4_ff) begin
         p5_ff   <= p5_in;
         s0_5_ff <= s0_4_ff;
         v1_5_ff <= v1_4_ff;
         f5_ff   <= f4_ff;
      end
   end

   // Stage 6: p1 times fraction
   assign prod6_in = PB'(p5_ff) * PB'($signed({1'b0, f5_ff}));

   always_ff @(posedge clock) begin
      if (ld6 && vld5_ff) begin
         prod6_ff <= prod6_in;
         s0_6_ff  <= s0_5_ff;
         v1_6_ff  <= v1_5_ff;
         f6_ff    <= f5_ff;
      end
   end

   // Stage 7: add S0, round half up to p2
   always_comb begin
      sum7  = MB'(prod6_ff) + (MB'(s0_6_ff) <<< FB) + whr_pkg::RND_HALF_F;
      p7_in = whr_pkg::P_BITS'(sum7 >>> FB);
   end

   always_ff @(posedge clock) begin
      if (ld7 && vld6_ff) begin
         p7_ff   <= p7_in;
         v1_7_ff <= v1_6_ff;
         f7_ff   <= f6_ff;
      end
   end

   // Stage 8: p2 times fraction
   assign prod8_in = PB'(p7_ff) * PB'($signed({1'b0, f7_ff}));

   always_ff @(posedge clock) begin
      if (ld8 && vld7_ff) begin
         prod8_ff <= prod8_in;
         v1_8_ff  <= v1_7_ff;
      end
   end

   // Stage 9: halve with rounding, add v1, saturate
   always_comb begin
      sum9     = MB'(prod8_ff) + whr_pkg::RND_HALF_F1;
      t9       = whr_pkg::P_BITS'(sum9 >>> (FB + 1));
      y9       = whr_pkg::Y_BITS'(v1_8_ff) + whr_pkg::Y_BITS'(t9);
      clip9_in = 1'b0;
      out9_in  = SB'(y9);
      if (y9 > whr_pkg::SAT_HI) begin
         out9_in  = SB'(whr_pkg::SAT_HI);
         clip9_in = 1'b1;
      end else if (y9 < whr_pkg::SAT_LO) begin
         out9_in  = SB'(whr_pkg::SAT_LO);
         clip9_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ld9 && vld8_ff) begin
         out9_ff  <= out9_in;
         clip9_ff <= clip9_in;
      end
   end

   assign rsp_bus.valid      = vld9_ff;
   assign rsp_bus.sample_out = out9_ff;
   assign rsp_bus.clipped    = clip9_ff;

endmodule
